FILE: sv/prca_pkg.sv
// Package for the packet receiver: result and queue-entry types, configuration
// record, event codes, phase codes and the bytewise CRC-32 update.
// Has no dependencies. Every other file of the block uses it.
package prca_pkg;

	// Fixed framing constants.
	localparam int unsigned PKT_HDR_BYTES = 6;
	localparam int unsigned CNT_LO_OFFSET = 8;
	localparam int unsigned CNT_HI_OFFSET = 12;
	localparam int unsigned CNT_END_OFFSET = 16;
	localparam int unsigned LEN_BYTES = 2;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_PACKET = 3'd1;
	localparam logic [2:0] REG_END = 3'd2;
	localparam logic [2:0] REG_NEXT = 3'd3;
	localparam logic [2:0] REG_AGAIN = 3'd4;

	typedef enum logic [2:0] {
		EV_HEADER = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_GOOD = 3'd2,
		EV_BAD = 3'd3,
		EV_PREMATURE = 3'd4,
		EV_BAD_CMD = 3'd5,
		EV_DONE = 3'd6,
		EV_COUNT_BIG = 3'd7
	} prca_event_t;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_HEADER = 6'b000010,
		PH_CMD = 6'b000100,
		PH_PKTHDR = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_END = 6'b100000
	} prca_phase_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] packet_code;
		logic [7:0] end_code;
		logic [7:0] next_code;
		logic [7:0] again_code;
	} prca_cfg_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic [31:0] packet_index;
		logic [15:0] byte_offset;
	} prca_res_t;

	// An entry holds the one or two results that one input byte causes; both travel together.
	typedef struct packed {
		logic two;
		prca_res_t first;
		prca_res_t second;
	} prca_entry_t;

	// Reflected CRC-32 update over one byte, one bit per step.
	function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: sv/prca_front.sv
// Front part of the packet receiver: protocol phase machine, CRC check and
// result classification, one byte per cycle while accept is high. Depends on prca_pkg.
module prca_front #(
	parameter int unsigned HEADER_BYTES = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  prca_pkg::prca_cfg_t  cfg,
	input  logic                 accept,
	input  logic [7:0]           link_byte,
	output logic                 ent_push,
	output prca_pkg::prca_entry_t ent
);

	prca_pkg::prca_phase_t phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n;
	logic [31:0] pe_q, pe_n;
	logic        ovf_q, ovf_n;
	logic [31:0] idx_q, idx_n;
	logic [15:0] len_q, len_n;
	logic [31:0] exp_q, exp_n;
	logic [31:0] crc_q, crc_n;

	always_comb begin
		logic [1:0]  nres;
		logic [16:0] cnt_inc;
		logic [31:0] crc_upd;
		logic [31:0] idx_inc;
		logic        good;
		prca_pkg::prca_res_t r0, r1, jr;

		phase_n = phase_q;
		cnt_n = cnt_q;
		pe_n = pe_q;
		ovf_n = ovf_q;
		idx_n = idx_q;
		len_n = len_q;
		exp_n = exp_q;
		crc_n = crc_q;
		nres = 2'd0;
		r0 = '0;
		r1 = '0;
		cnt_inc = {1'b0, cnt_q} + 17'd1;
		crc_upd = prca_pkg::crc32_byte(crc_q, link_byte);
		idx_inc = idx_q + 32'd1;
		good = 1'b0;
		jr = '0;

		case (phase_q)
			prca_pkg::PH_HEADER: begin
				nres = 2'd1;
				r0 = '{prca_pkg::EV_HEADER, link_byte, idx_q, cnt_q};
				if (cnt_q >= 16'(prca_pkg::CNT_LO_OFFSET) && cnt_q < 16'(prca_pkg::CNT_HI_OFFSET)) begin
					pe_n = pe_q | ({24'd0, link_byte} << {cnt_q[1:0], 3'd0});
				end else if (cnt_q >= 16'(prca_pkg::CNT_HI_OFFSET)
						&& cnt_q < 16'(prca_pkg::CNT_END_OFFSET) && link_byte != 8'd0) begin
					ovf_n = 1'b1;
				end
				if (cnt_inc >= 17'(HEADER_BYTES)) begin
					cnt_n = '0;
					if (ovf_n) begin
						nres = 2'd2;
						r1 = '{prca_pkg::EV_COUNT_BIG, 8'd0, idx_q, 16'd0};
						phase_n = prca_pkg::PH_IDLE;
					end else begin
						phase_n = (pe_n == 32'd0) ? prca_pkg::PH_END : prca_pkg::PH_CMD;
					end
				end else begin
					cnt_n = cnt_inc[15:0];
				end
			end
			prca_pkg::PH_CMD: begin
				if (link_byte == cfg.end_code) begin
					nres = 2'd1;
					r0 = '{prca_pkg::EV_PREMATURE, link_byte, idx_q, 16'd0};
					phase_n = prca_pkg::PH_IDLE;
				end else if (link_byte != cfg.packet_code) begin
					nres = 2'd1;
					r0 = '{prca_pkg::EV_BAD_CMD, link_byte, idx_q, 16'd0};
					phase_n = prca_pkg::PH_IDLE;
				end else begin
					phase_n = prca_pkg::PH_PKTHDR;
					cnt_n = '0;
					len_n = '0;
					exp_n = '0;
				end
			end
			prca_pkg::PH_PKTHDR: begin
				if (cnt_q < 16'(prca_pkg::LEN_BYTES)) begin
					len_n = len_q | ({8'd0, link_byte} << {cnt_q[0], 3'd0});
				end else begin
					exp_n = exp_q | ({24'd0, link_byte} << {cnt_q[1:0] - 2'd2, 3'd0});
				end
				cnt_n = cnt_inc[15:0];
				if (cnt_inc >= 17'(prca_pkg::PKT_HDR_BYTES)) begin
					cnt_n = '0;
					crc_n = prca_pkg::CRC_INIT;
					if (len_n == 16'd0) begin
						// Empty payload: the CRC of nothing is zero.
						good = (exp_n == 32'd0);
						nres = 2'd1;
					end else begin
						phase_n = prca_pkg::PH_PAYLOAD;
					end
				end
			end
			prca_pkg::PH_PAYLOAD: begin
				nres = 2'd1;
				r0 = '{prca_pkg::EV_PAYLOAD, link_byte, idx_q, cnt_q};
				crc_n = crc_upd;
				if (cnt_inc >= {1'b0, len_q}) begin
					cnt_n = '0;
					good = ((~crc_upd) == exp_q);
					nres = 2'd2;
				end else begin
					cnt_n = cnt_inc[15:0];
				end
			end
			prca_pkg::PH_END: begin
				nres = 2'd1;
				r0 = '{(link_byte == cfg.end_code) ? prca_pkg::EV_DONE : prca_pkg::EV_BAD_CMD,
					link_byte, idx_q, 16'd0};
				phase_n = prca_pkg::PH_IDLE;
			end
			default: begin
				if (link_byte == cfg.start_code) begin
					phase_n = prca_pkg::PH_HEADER;
					cnt_n = '0;
					pe_n = '0;
					ovf_n = 1'b0;
					idx_n = '0;
				end else begin
					nres = 2'd1;
					r0 = '{prca_pkg::EV_BAD_CMD, link_byte, idx_q, 16'd0};
					phase_n = prca_pkg::PH_IDLE;
				end
			end
		endcase

		// Packet verdict, taken at the end of a payload or of an empty packet's header.
		if ((phase_q == prca_pkg::PH_PKTHDR && nres == 2'd1)
				|| (phase_q == prca_pkg::PH_PAYLOAD && nres == 2'd2)) begin
			if (good) begin
				jr = '{prca_pkg::EV_GOOD, cfg.next_code, idx_q, 16'd0};
				idx_n = idx_inc;
				phase_n = (idx_inc == pe_q) ? prca_pkg::PH_END : prca_pkg::PH_CMD;
			end else begin
				jr = '{prca_pkg::EV_BAD, cfg.again_code, idx_q, 16'd0};
				phase_n = prca_pkg::PH_CMD;
			end
			if (phase_q == prca_pkg::PH_PKTHDR) begin
				r0 = jr;
			end else begin
				r1 = jr;
			end
		end

		ent_push = accept && (nres != 2'd0);
		ent.two = (nres == 2'd2);
		ent.first = r0;
		ent.second = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= prca_pkg::PH_IDLE;
			cnt_q <= '0;
			pe_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			len_q <= '0;
			exp_q <= '0;
			crc_q <= prca_pkg::CRC_INIT;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			pe_q <= pe_n;
			ovf_q <= ovf_n;
			idx_q <= idx_n;
			len_q <= len_n;
			exp_q <= exp_n;
			crc_q <= crc_n;
		end
	end

endmodule

FILE: sv/prca_queue.sv
// Short queue of classified entries between the front and back parts.
// Depends on prca_pkg.
module prca_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  prca_pkg::prca_entry_t wr_data,
	input  logic                  rd_en,
	output prca_pkg::prca_entry_t rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	prca_pkg::prca_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/prca_back.sv
// Back part of the packet receiver: unpacks each entry into one or two
// results held in an output register. Depends on prca_pkg.
module prca_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prca_pkg::prca_entry_t q_data,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [2:0]            event_res,
	output logic [7:0]            data_byte,
	output logic [31:0]           packet_index,
	output logic [15:0]           byte_offset,
	output logic                  last
);

	prca_pkg::prca_entry_t ent_q;
	prca_pkg::prca_res_t   cur;
	logic valid_q, sel_q;
	logic taken, finish;

	assign taken = valid_q && pop;
	assign finish = taken && (!ent_q.two || sel_q);
	assign q_pop = !q_empty && (!valid_q || finish);

	assign cur = sel_q ? ent_q.second : ent_q.first;
	assign empty = !valid_q;
	assign event_res = cur.event_res;
	assign data_byte = cur.data_byte;
	assign packet_index = cur.packet_index;
	assign byte_offset = cur.byte_offset;
	assign last = !ent_q.two || sel_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (finish) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (taken) begin
			sel_q <= 1'b1;
		end
	end

endmodule

FILE: sv/packet_receiver_crc_ack_core.sv
// Top level of the stop-and-wait packet receiver with CRC-32 check.
// Depends on prca_pkg, prca_front, prca_queue and prca_back.

// The receiver takes one link byte per cycle through a push/full queue port
// and answers through an empty/pop queue port. It waits for the start command,
// passes the header through (the packet count sits in header bytes 8 to 15,
// little endian), then checks each packet: packet command, 16-bit length,
// 32-bit CRC and payload. Payload bytes are passed on, and every packet ends
// in a good item carrying next_code or a bad item carrying again_code. A byte
// is taken in the cycle it is pushed whenever the entry queue has room, so the
// front sustains one byte per cycle. A byte causes at most two result items;
// the back part delivers one result item per cycle while pop is high, so bytes
// that cause two items (the last header byte with too large a count, the last
// payload byte) need a pop per item, and the QUEUE_DEPTH-entry queue between
// the parts absorbs that and any stall on the result side. The bytewise CRC
// update and phase step are both combinational in the front. The command and
// response codes must be written through the APB port while the block is
// idle; the block does not enforce this. Register i is at byte address 4*i.
module packet_receiver_crc_ack_core #(
	parameter int unsigned HEADER_BYTES = 48,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  link_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [31:0] packet_index,
	output logic [15:0] byte_offset,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	prca_pkg::prca_cfg_t   cfg_q;
	prca_pkg::prca_entry_t f_ent, q_data;
	logic accept, f_push, q_empty, q_pop, cfg_wr;
	logic [7:0] rd_byte;

	// Configuration registers; the register index comes from paddr[4:2].
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= 8'd1;
			cfg_q.packet_code <= 8'd2;
			cfg_q.end_code <= 8'd3;
			cfg_q.next_code <= 8'd4;
			cfg_q.again_code <= 8'd5;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				prca_pkg::REG_START: cfg_q.start_code <= pwdata[7:0];
				prca_pkg::REG_PACKET: cfg_q.packet_code <= pwdata[7:0];
				prca_pkg::REG_END: cfg_q.end_code <= pwdata[7:0];
				prca_pkg::REG_NEXT: cfg_q.next_code <= pwdata[7:0];
				prca_pkg::REG_AGAIN: cfg_q.again_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			prca_pkg::REG_START: rd_byte = cfg_q.start_code;
			prca_pkg::REG_PACKET: rd_byte = cfg_q.packet_code;
			prca_pkg::REG_END: rd_byte = cfg_q.end_code;
			prca_pkg::REG_NEXT: rd_byte = cfg_q.next_code;
			prca_pkg::REG_AGAIN: rd_byte = cfg_q.again_code;
			default: rd_byte = 8'd0;
		endcase
	end
	assign prdata = {24'd0, rd_byte};

	// A byte is accepted whenever the entry queue has room.
	assign accept = push && !full;

	prca_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.link_byte(link_byte),
		.ent_push(f_push),
		.ent(f_ent)
	);

	prca_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(f_push),
		.wr_data(f_ent),
		.rd_en(q_pop),
		.rd_data(q_data),
		.full(full),
		.empty(q_empty)
	);

	prca_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_data(q_data),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.event_res(event_res),
		.data_byte(data_byte),
		.packet_index(packet_index),
		.byte_offset(byte_offset),
		.last(last)
	);

endmodule

FILE: verif/packet_receiver_crc_ack_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_receiver_crc_ack_core: a frame-level predictor
// follows the receive protocol and CRC, and every popped result item is matched in order.
// Depends on prca_pkg and the block's RTL; needs nothing else.

import prca_pkg::*;

localparam int unsigned HDR_LEN = 48;

typedef struct {
	prca_res_t res;
	logic fin;
} awaited_t;

// Tracks the receiver's protocol state and the result items each link byte should cause.
class rx_frame_checker;
	prca_cfg_t codes;
	prca_phase_t phase;
	int unsigned field_pos;
	logic [31:0] pkt_total;
	bit count_wide;
	logic [31:0] pkt_idx;
	logic [15:0] pay_len;
	logic [31:0] crc_given;
	logic [31:0] crc_run;
	awaited_t awaited[$];
	int unsigned misses;
	int unsigned matched;
	int unsigned per_event[8];
	int unsigned made_now;

	function new();
		misses = 0;
		matched = 0;
		foreach (per_event[i]) per_event[i] = 0;
		codes.start_code = 8'd1;
		codes.packet_code = 8'd2;
		codes.end_code = 8'd3;
		codes.next_code = 8'd4;
		codes.again_code = 8'd5;
		phase = PH_IDLE;
		field_pos = 0;
		pkt_total = '0;
		count_wide = 1'b0;
		pkt_idx = '0;
		pay_len = '0;
		crc_given = '0;
		crc_run = CRC_INIT;
	endfunction

	// Reflected CRC-32 step, one message bit at a time from the LSB.
	static function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function void set_code(logic [2:0] idx, logic [7:0] v);
		case (idx)
			REG_START: codes.start_code = v;
			REG_PACKET: codes.packet_code = v;
			REG_END: codes.end_code = v;
			REG_NEXT: codes.next_code = v;
			REG_AGAIN: codes.again_code = v;
			default: ;
		endcase
	endfunction

	task note_miss(string what);
		misses++;
		if (misses <= 40) $display("MISMATCH: %s", what);
	endtask

	function void add(prca_event_t ev, logic [7:0] d, logic [15:0] off);
		awaited_t a;
		if (made_now > 0) awaited[awaited.size() - 1].fin = 1'b0;
		a.res.event_res = ev;
		a.res.data_byte = d;
		a.res.packet_index = pkt_idx;
		a.res.byte_offset = off;
		a.fin = 1'b1;
		awaited.push_back(a);
		made_now++;
	endfunction

	// A packet is judged after its last payload byte, or right after its header when empty.
	function void judge();
		if (~crc_run == crc_given) begin
			add(EV_GOOD, codes.next_code, 16'd0);
			pkt_idx++;
			phase = (pkt_idx == pkt_total) ? PH_END : PH_CMD;
		end else begin
			add(EV_BAD, codes.again_code, 16'd0);
			phase = PH_CMD;
		end
	endfunction

	function void take_link_byte(logic [7:0] b);
		made_now = 0;
		case (phase)
			PH_HEADER: begin
				add(EV_HEADER, b, field_pos[15:0]);
				if (field_pos >= CNT_LO_OFFSET && field_pos < CNT_HI_OFFSET)
					pkt_total |= {24'd0, b} << (8 * (field_pos - CNT_LO_OFFSET));
				else if (field_pos >= CNT_HI_OFFSET && field_pos < CNT_END_OFFSET && b != 8'd0)
					count_wide = 1'b1;
				if (field_pos + 1 >= HDR_LEN) begin
					field_pos = 0;
					if (count_wide) begin
						add(EV_COUNT_BIG, 8'd0, 16'd0);
						phase = PH_IDLE;
					end else begin
						phase = (pkt_total == 0) ? PH_END : PH_CMD;
					end
				end else begin
					field_pos++;
				end
			end
			PH_CMD: begin
				if (b == codes.end_code) begin
					add(EV_PREMATURE, b, 16'd0);
					phase = PH_IDLE;
				end else if (b != codes.packet_code) begin
					add(EV_BAD_CMD, b, 16'd0);
					phase = PH_IDLE;
				end else begin
					phase = PH_PKTHDR;
					field_pos = 0;
					pay_len = '0;
					crc_given = '0;
				end
			end
			PH_PKTHDR: begin
				if (field_pos < LEN_BYTES)
					pay_len |= {8'd0, b} << (8 * field_pos);
				else
					crc_given |= {24'd0, b} << (8 * ((field_pos - LEN_BYTES) % 4));
				field_pos++;
				if (field_pos >= PKT_HDR_BYTES) begin
					field_pos = 0;
					crc_run = CRC_INIT;
					if (pay_len == 0) judge();
					else phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				add(EV_PAYLOAD, b, field_pos[15:0]);
				crc_run = crc_fold(crc_run, b);
				if (field_pos + 1 >= pay_len) begin
					field_pos = 0;
					judge();
				end else begin
					field_pos++;
				end
			end
			PH_END: begin
				add((b == codes.end_code) ? EV_DONE : EV_BAD_CMD, b, 16'd0);
				phase = PH_IDLE;
			end
			default: begin
				if (b == codes.start_code) begin
					phase = PH_HEADER;
					field_pos = 0;
					pkt_total = '0;
					count_wide = 1'b0;
					pkt_idx = '0;
				end else begin
					add(EV_BAD_CMD, b, 16'd0);
					phase = PH_IDLE;
				end
			end
		endcase
	endfunction

	task match_result(prca_res_t got, logic got_fin);
		awaited_t w;
		if (awaited.size() == 0) begin
			note_miss($sformatf("unexpected item: ev %0d data %02h idx %0d off %0d last %0b",
				got.event_res, got.data_byte, got.packet_index, got.byte_offset, got_fin));
			return;
		end
		w = awaited.pop_front();
		matched++;
		per_event[w.res.event_res]++;
		if (got !== w.res || got_fin !== w.fin)
			note_miss($sformatf({"item %0d: got ev %0d data %02h idx %0d off %0d last %0b,",
				" want ev %0d data %02h idx %0d off %0d last %0b"}, matched,
				got.event_res, got.data_byte, got.packet_index, got.byte_offset, got_fin,
				w.res.event_res, w.res.data_byte, w.res.packet_index, w.res.byte_offset, w.fin));
	endtask

	task wrap_up();
		if (awaited.size() != 0)
			note_miss($sformatf("%0d expected items never arrived", awaited.size()));
	endtask
endclass

module packet_receiver_crc_ack_core_test;

	// Generous watchdog: the run is roughly a thousand link bytes, each causing
	// at most two items, so even heavy stalls stay far below this.
	localparam int unsigned LIMIT = 2_000_000;

	typedef enum int {
		K_GOOD,
		K_EMPTY_PKT,
		K_ZERO,
		K_WIDE,
		K_EARLY_END,
		K_WRONG_CMD,
		K_NOISE
	} frame_kind_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] link_byte;
	logic empty;
	logic pop;
	logic [2:0] event_res;
	logic [7:0] data_byte;
	logic [31:0] packet_index;
	logic [15:0] byte_offset;
	logic last;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rx_frame_checker chk;
	logic [7:0] frame_bytes[$];
	int unsigned stim_count = 0;
	int unsigned cycle_count = 0;
	int unsigned settings_done = 0;
	// Idling switches: per frame, each side may run without gaps; the final
	// part of the run turns idling off on both sides.
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit no_idle = 1'b0;

	packet_receiver_crc_ack_core #(
		.HEADER_BYTES(HDR_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.link_byte(link_byte),
		.empty(empty),
		.pop(pop),
		.event_res(event_res),
		.data_byte(data_byte),
		.packet_index(packet_index),
		.byte_offset(byte_offset),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT);
		$display("packet_receiver_crc_ack_core verification failed");
		$finish;
	end

	// Result side: pop changes at the falling edge, stalling in random bursts
	// unless idling is off for the current stretch.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (!rx_calm && !no_idle && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 16) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// A result item is taken at a rising edge with pop high and empty low; the
	// values read here are the ones that stood before the edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			chk.match_result({event_res, data_byte, packet_index, byte_offset}, last);
	end

	// Pushes one link byte, entered and left at a falling edge. The predictor
	// sees the byte at the edge that accepts it.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (!tx_calm && !no_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		link_byte <= b;
		do @(posedge clk); while (full);
		chk.take_link_byte(b);
		stim_count++;
		@(negedge clk);
	endtask

	// Lowers push and waits until every predicted item has popped. Bytes that
	// cause no item may still be in flight, so a further wait follows the drain.
	task automatic drain_results();
		push <= 1'b0;
		while (chk.awaited.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write of one code register, then a read-back through the same port.
	task automatic write_code(input logic [2:0] idx, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		chk.set_code(idx, v);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== v)
			chk.note_miss($sformatf("register %0d reads %02h, written %02h", idx, prdata[7:0], v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_codes(input logic [7:0] st, input logic [7:0] pk, input logic [7:0] en,
			input logic [7:0] nx, input logic [7:0] ag);
		drain_results();
		write_code(REG_START, st);
		write_code(REG_PACKET, pk);
		write_code(REG_END, en);
		write_code(REG_NEXT, nx);
		write_code(REG_AGAIN, ag);
		settings_done++;
	endtask

	function automatic logic [7:0] other_than(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		do r = 8'($urandom); while (r == a || r == b);
		return r;
	endfunction

	// Start command and header; the packet count sits at offsets 8 to 15.
	function automatic void put_header(input logic [31:0] lo, input logic [31:0] hi);
		frame_bytes.push_back(chk.codes.start_code);
		for (int i = 0; i < HDR_LEN; i++) begin
			if (i >= CNT_LO_OFFSET && i < CNT_HI_OFFSET)
				frame_bytes.push_back(lo[8 * (i - CNT_LO_OFFSET) +: 8]);
			else if (i >= CNT_HI_OFFSET && i < CNT_END_OFFSET)
				frame_bytes.push_back(hi[8 * (i - CNT_HI_OFFSET) +: 8]);
			else
				frame_bytes.push_back(8'($urandom));
		end
	endfunction

	// One packet with random payload; a spoiled CRC has one bit flipped.
	function automatic void put_packet(input logic [15:0] len, input bit spoil);
		logic [7:0] body[$];
		logic [7:0] v;
		logic [31:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			v = 8'($urandom);
			body.push_back(v);
			crc = chk.crc_fold(crc, v);
		end
		crc = ~crc;
		if (spoil) crc ^= 32'd1 << $urandom_range(0, 31);
		frame_bytes.push_back(chk.codes.packet_code);
		frame_bytes.push_back(len[7:0]);
		frame_bytes.push_back(len[15:8]);
		for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8 * i +: 8]);
		foreach (body[i]) frame_bytes.push_back(body[i]);
	endfunction

	// Mostly short payloads, some empty ones and a few of 250 to 300 bytes.
	function automatic logic [15:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) return 16'd0;
		if (r < 95) return 16'($urandom_range(1, 24));
		return 16'($urandom_range(250, 300));
	endfunction

	// A bad CRC draws an again answer, so the sender retries until one gets through.
	function automatic void put_acked_packet(input logic [15:0] len);
		while ($urandom_range(0, 4) == 0) put_packet(len, 1'b1);
		put_packet(len, 1'b0);
	endfunction

	task automatic send_frame(input frame_kind_t kind);
		int unsigned n;
		int unsigned sent;
		logic [31:0] lo;
		logic [31:0] hi;
		frame_bytes.delete();
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		case (kind)
			K_GOOD: begin
				n = $urandom_range(1, 3);
				put_header(n, 0);
				repeat (n) put_acked_packet(pick_len());
				frame_bytes.push_back(chk.codes.end_code);
			end
			K_EMPTY_PKT: begin
				// Empty payloads are judged straight after the packet header.
				put_header(2, 0);
				put_packet(16'd0, 1'b1);
				put_packet(16'd0, 1'b0);
				put_packet(16'd0, 1'b0);
				frame_bytes.push_back(chk.codes.end_code);
			end
			K_ZERO: begin
				// A zero count goes straight to awaiting the end command.
				put_header(0, 0);
				if ($urandom_range(0, 2) == 0)
					frame_bytes.push_back(other_than(chk.codes.end_code, chk.codes.end_code));
				else
					frame_bytes.push_back(chk.codes.end_code);
			end
			K_WIDE: begin
				// Any nonzero byte in the upper half of the count is flagged.
				lo = $urandom;
				if ($urandom_range(0, 1) == 0)
					hi = 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
				else
					do hi = $urandom; while (hi == 0);
				put_header(lo, hi);
			end
			K_EARLY_END: begin
				// End command while packets are still owed.
				lo = $urandom;
				if (lo < 2) lo = 2;
				put_header(lo, 0);
				repeat ($urandom_range(0, 1)) put_acked_packet(pick_len());
				frame_bytes.push_back(chk.codes.end_code);
			end
			K_WRONG_CMD: begin
				// A foreign byte where a command is due, either a packet command
				// or, once all packets are in, the end command.
				n = $urandom_range(1, 3);
				sent = $urandom_range(0, n);
				put_header(n, 0);
				repeat (sent) put_acked_packet(pick_len());
				frame_bytes.push_back(other_than(chk.codes.end_code, chk.codes.packet_code));
			end
			default: begin
				repeat ($urandom_range(1, 6))
					frame_bytes.push_back(other_than(chk.codes.start_code, chk.codes.start_code));
			end
		endcase
		foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
	endtask

	// Random frames, weighted toward complete transfers, until the quota of bytes is in.
	task automatic run_frames(input int unsigned quota);
		int unsigned first;
		int unsigned r;
		first = stim_count;
		while (stim_count - first < quota) begin
			r = $urandom_range(0, 9);
			if (r < 4) send_frame(K_GOOD);
			else if (r == 4) send_frame(K_EMPTY_PKT);
			else if (r == 5) send_frame(K_ZERO);
			else if (r == 6) send_frame(K_WIDE);
			else if (r == 7) send_frame(K_EARLY_END);
			else if (r == 8) send_frame(K_WRONG_CMD);
			else send_frame(K_NOISE);
		end
	endtask

	initial begin
		logic [7:0] st;
		logic [7:0] pk;
		logic [7:0] en;
		arst_n = 1'b0;
		push = 1'b0;
		link_byte = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 5'd0;
		pwdata = 32'd0;
		chk = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening with the reset codes: stray bytes while idle, among
		// them the extremes and the packet and end commands, then one frame of
		// every kind.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(chk.codes.packet_code);
		send_byte(chk.codes.end_code);
		for (int k = K_GOOD; k <= K_NOISE; k++) send_frame(frame_kind_t'(k));
		run_frames(40);

		// Extreme code settings, inverted against each other.
		apply_codes(8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF);
		run_frames(40);
		apply_codes(8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h00);
		run_frames(40);

		// Packet and end commands share a code: the end reading wins, so a
		// transfer that still owes packets can only ever end early.
		pk = 8'($urandom);
		apply_codes(other_than(pk, pk), pk, pk, 8'($urandom), 8'($urandom));
		run_frames(20);

		// Random distinct codes, and no idling on either side from here on,
		// starting with one packet whose length needs both length bytes.
		st = 8'($urandom);
		pk = other_than(st, st);
		en = other_than(st, pk);
		apply_codes(st, pk, en, 8'($urandom), 8'($urandom));
		no_idle = 1'b1;
		frame_bytes.delete();
		put_header(1, 0);
		put_packet(16'd300, 1'b0);
		frame_bytes.push_back(chk.codes.end_code);
		foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
		run_frames(40);

		drain_results();
		repeat (16) @(posedge clk);
		chk.wrap_up();
		$display("Summary: %0d link bytes over %0d code settings plus reset codes, %0d items checked.",
			stim_count, settings_done, chk.matched);
		$display("Items by event: hdr %0d pay %0d good %0d bad %0d early %0d cmd %0d done %0d wide %0d",
			chk.per_event[EV_HEADER], chk.per_event[EV_PAYLOAD], chk.per_event[EV_GOOD],
			chk.per_event[EV_BAD], chk.per_event[EV_PREMATURE], chk.per_event[EV_BAD_CMD],
			chk.per_event[EV_DONE], chk.per_event[EV_COUNT_BIG]);
		if (chk.misses == 0) begin
			$display("packet_receiver_crc_ack_core verification clean");
		end else begin
			$display("packet_receiver_crc_ack_core verification failed");
		end
		$finish;
	end

endmodule

FILE: packet_receiver_crc_ack_core.f
sv/prca_pkg.sv
sv/prca_front.sv
sv/prca_queue.sv
sv/prca_back.sv
sv/packet_receiver_crc_ack_core.sv
verif/packet_receiver_crc_ack_core_test.sv
